// ===== rtl/classify_chain_type_defines.svh =====
// ----------------------------------------------------------------------------
// Chain classifier assertion macros
// Shared concurrent assertion forms for the chain classifier RTL.
// ----------------------------------------------------------------------------
`ifndef CLASSIFY_CHAIN_TYPE_DEFINES_SVH
`define CLASSIFY_CHAIN_TYPE_DEFINES_SVH

// same-cycle implication
`define CCT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CCT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// Chain classifier package
// Class codes, residue name constants, CSR map and shared types.
// ----------------------------------------------------------------------------
package cct_pkg;

   localparam int CountWidthDefault = 16;
   localparam int TotalWidth        = 16;
   localparam int CsrIndexWidth     = 2;
   localparam int CsrDataWidth      = 16;
   localparam int NameWidth         = 24;

   // CSR indexes
   localparam logic [CsrIndexWidth-1:0] CsrCountPeptides   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrCountNonstd     = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrPeptideLimit    = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CsrUnknownPctLimit = 2'd3;

   // CSR reset values
   localparam logic [15:0] PeptideLimitReset    = 16'd30;
   localparam logic [6:0]  UnknownPctLimitReset = 7'd25;
   localparam logic [7:0]  PercentScale         = 8'd100;

   // residue names, first character in the top byte
   localparam logic [NameWidth-1:0] NameA  = "  A";
   localparam logic [NameWidth-1:0] NameC  = "  C";
   localparam logic [NameWidth-1:0] NameI  = "  I";
   localparam logic [NameWidth-1:0] NameG  = "  G";
   localparam logic [NameWidth-1:0] NameU  = "  U";
   localparam logic [NameWidth-1:0] NameIU = " IU";
   localparam logic [NameWidth-1:0] NameDA = " DA";
   localparam logic [NameWidth-1:0] NameDT = " DT";
   localparam logic [NameWidth-1:0] NameT  = "  T";
   localparam logic [NameWidth-1:0] NameDC = " DC";
   localparam logic [NameWidth-1:0] NameDI = " DI";
   localparam logic [NameWidth-1:0] NameDG = " DG";

   typedef enum logic [2:0] {
      CLASS_UNDEF   = 3'd0,
      CLASS_RNA     = 3'd1,
      CLASS_DNA     = 3'd2,
      CLASS_PROTEIN = 3'd3,
      CLASS_HYBRID  = 3'd4,
      CLASS_PEPTIDE = 3'd5,
      CLASS_NONSTD  = 3'd6
   } chain_class_type;

   typedef enum logic [1:0] {
      GROUP_BASE   = 2'd0,  // A C I G
      GROUP_URACIL = 2'd1,  // U IU
      GROUP_DEOXY  = 2'd2,  // DNA nucleotides
      GROUP_OTHER  = 2'd3
   } res_group_type;

   typedef struct packed {
      chain_class_type running_class;
      logic            seen_uracil;
   } chain_state_type;

   typedef struct packed {
      logic        count_peptides;
      logic        count_nonstandard;
      logic [15:0] peptide_length_limit;
      logic [6:0]  unknown_percent_limit;
   } cfg_type;

endpackage

// ===== rtl/cct_step.sv =====
// ----------------------------------------------------------------------------
// Chain classifier step
// Per-residue class/count update and end-of-chain result decision.
// ----------------------------------------------------------------------------
module cct_step #(
   parameter int CountWidth = cct_pkg::CountWidthDefault
) (
   input  cct_pkg::chain_state_type             state_cur,
   input  logic [CountWidth-1:0]                residue_cur,
   input  logic [CountWidth-1:0]                unknown_cur,
   input  logic [cct_pkg::NameWidth-1:0]        residue_name,
   input  logic                                 unknown_residue,
   input  logic                                 last_residue,
   input  cct_pkg::cfg_type                     cfg,
   output cct_pkg::chain_state_type             state_next,
   output logic [CountWidth-1:0]                residue_next,
   output logic [CountWidth-1:0]                unknown_next,
   output cct_pkg::chain_class_type             result_class,
   output logic [cct_pkg::TotalWidth-1:0]       result_total
);

   localparam int ProdWidth = CountWidth + 8;
   localparam int CmpWidth  = (CountWidth > cct_pkg::TotalWidth) ?
                              CountWidth : cct_pkg::TotalWidth;

   cct_pkg::res_group_type   group;
   cct_pkg::chain_class_type cls_upd;
   logic                     uracil_upd;
   logic [CountWidth-1:0]    residue_upd;
   logic [CountWidth-1:0]    unknown_upd;
   logic [ProdWidth-1:0]     unknown_scaled;
   logic [ProdWidth-1:0]     residue_scaled;
   logic [7:0]               limit_plus1;
   logic [CmpWidth-1:0]      residue_wide;

   always_comb begin
      unique case (residue_name) inside
         cct_pkg::NameA, cct_pkg::NameC, cct_pkg::NameI, cct_pkg::NameG:
            group = cct_pkg::GROUP_BASE;
         cct_pkg::NameU, cct_pkg::NameIU:
            group = cct_pkg::GROUP_URACIL;
         cct_pkg::NameDA, cct_pkg::NameDT, cct_pkg::NameT,
         cct_pkg::NameDC, cct_pkg::NameDI, cct_pkg::NameDG:
            group = cct_pkg::GROUP_DEOXY;
         default:
            group = cct_pkg::GROUP_OTHER;
      endcase
   end

   always_comb begin
      cls_upd    = state_cur.running_class;
      uracil_upd = state_cur.seen_uracil;
      case (group)
         cct_pkg::GROUP_BASE: begin
            if (state_cur.running_class == cct_pkg::CLASS_UNDEF) begin
               cls_upd = cct_pkg::CLASS_RNA;
            end else if (state_cur.running_class == cct_pkg::CLASS_PROTEIN) begin
               cls_upd = cct_pkg::CLASS_HYBRID;
            end
         end
         cct_pkg::GROUP_URACIL: begin
            uracil_upd = 1'b1;
            if (state_cur.running_class == cct_pkg::CLASS_UNDEF) begin
               cls_upd = cct_pkg::CLASS_RNA;
            end else if (state_cur.running_class == cct_pkg::CLASS_DNA ||
                         state_cur.running_class == cct_pkg::CLASS_PROTEIN) begin
               cls_upd = cct_pkg::CLASS_HYBRID;
            end
         end
         cct_pkg::GROUP_DEOXY: begin
            if (state_cur.running_class == cct_pkg::CLASS_UNDEF ||
                state_cur.running_class == cct_pkg::CLASS_RNA) begin
               cls_upd = state_cur.seen_uracil ? cct_pkg::CLASS_HYBRID :
                                                 cct_pkg::CLASS_DNA;
            end else if (state_cur.running_class != cct_pkg::CLASS_DNA) begin
               cls_upd = cct_pkg::CLASS_HYBRID;
            end
         end
         default: begin
            if (state_cur.running_class == cct_pkg::CLASS_UNDEF) begin
               cls_upd = cct_pkg::CLASS_PROTEIN;
            end else if (state_cur.running_class != cct_pkg::CLASS_PROTEIN) begin
               cls_upd = cct_pkg::CLASS_HYBRID;
            end
         end
      endcase
   end

   // saturating counts
   assign residue_upd = (residue_cur == '1) ? residue_cur : residue_cur + 1'b1;
   assign unknown_upd = (unknown_residue && unknown_cur != '1) ?
                        unknown_cur + 1'b1 : unknown_cur;

   // floor(100*unk/res) > limit  <=>  100*unk >= (limit+1)*res
   assign limit_plus1    = {1'b0, cfg.unknown_percent_limit} + 8'd1;
   assign unknown_scaled = ProdWidth'(unknown_upd) * ProdWidth'(cct_pkg::PercentScale);
   assign residue_scaled = ProdWidth'(residue_upd) * ProdWidth'(limit_plus1);
   assign residue_wide   = CmpWidth'(residue_upd);

   always_comb begin
      result_class = cls_upd;
      if (cfg.count_peptides && cls_upd == cct_pkg::CLASS_PROTEIN &&
          residue_wide < CmpWidth'(cfg.peptide_length_limit)) begin
         result_class = cct_pkg::CLASS_PEPTIDE;
      end
      if (cfg.count_nonstandard && unknown_scaled >= residue_scaled) begin
         result_class = cct_pkg::CLASS_NONSTD;
      end
      if (residue_wide > CmpWidth'({cct_pkg::TotalWidth{1'b1}})) begin
         result_total = '1;
      end else begin
         result_total = residue_wide[cct_pkg::TotalWidth-1:0];
      end
   end

   // the last residue leaves a clean slate for the next chain
   always_comb begin
      if (last_residue) begin
         state_next.running_class = cct_pkg::CLASS_UNDEF;
         state_next.seen_uracil   = 1'b0;
         residue_next             = '0;
         unknown_next             = '0;
      end else begin
         state_next.running_class = cls_upd;
         state_next.seen_uracil   = uracil_upd;
         residue_next             = residue_upd;
         unknown_next             = unknown_upd;
      end
   end

endmodule

// ===== rtl/classify_chain_type.sv =====
// ----------------------------------------------------------------------------
// Chain type classifier
// One residue per request on req_*; on the residue marked last, one result
// (chain class, residue total) goes out on rsp_*. Non-last residues give none.
// Each accepted request sits in an input register; from there the running
// class/counts update and, for a last residue, the result register loads
// and drives rsp_valid. Throughput: one request per clock while req_stall
// is low, bound by the class/count update loop.
// A stalled result blocks only a following last residue; other residues
// keep flowing while the result waits. req_stall rises when the input
// register holds a last residue that cannot move into a full result register.
// csr_* writes the mode bits and limits; write only while idle.
// Synchronous reset empties both registers, clears the chain state and
// restores the CSR defaults (peptide limit 30, unknown limit 25 percent).
// ----------------------------------------------------------------------------
`include "classify_chain_type_defines.svh"

module classify_chain_type #(
   parameter int CountWidth = cct_pkg::CountWidthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [cct_pkg::NameWidth-1:0]      req_residue_name,
   input  logic                               req_unknown_residue,
   input  logic                               req_last_residue,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_chain_class,
   output logic [cct_pkg::TotalWidth-1:0]     rsp_residue_total,
   // CSR write port
   input  logic                               csr_write,
   input  logic [cct_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [cct_pkg::CsrDataWidth-1:0]   csr_wdata
);

   // CSRs
   cct_pkg::cfg_type cfg_ff, cfg_in;

   // input register
   logic                          s1_valid_ff, s1_valid_in;
   logic [cct_pkg::NameWidth-1:0] s1_name_ff;
   logic                          s1_unknown_ff;
   logic                          s1_last_ff;

   // chain state
   cct_pkg::chain_state_type state_ff, state_in;
   logic [CountWidth-1:0]    residue_cnt_ff, residue_cnt_in;
   logic [CountWidth-1:0]    unknown_cnt_ff, unknown_cnt_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   cct_pkg::chain_class_type        rsp_class_ff;
   logic [cct_pkg::TotalWidth-1:0]  rsp_total_ff;

   cct_pkg::chain_class_type        step_class;
   logic [cct_pkg::TotalWidth-1:0]  step_total;

   logic req_accept;
   logic s1_adv;      // input register item is processed this cycle
   logic s1_emit;     // ... and it produces a result

   // a last residue may only move on when the result register has room
   assign s1_adv    = s1_valid_ff && !(s1_last_ff && rsp_valid_ff && rsp_stall);
   assign s1_emit   = s1_adv && s1_last_ff;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   // CSR decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            cct_pkg::CsrCountPeptides:   cfg_in.count_peptides = csr_wdata[0];
            cct_pkg::CsrCountNonstd:     cfg_in.count_nonstandard = csr_wdata[0];
            cct_pkg::CsrPeptideLimit:    cfg_in.peptide_length_limit = csr_wdata;
            cct_pkg::CsrUnknownPctLimit: cfg_in.unknown_percent_limit = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_peptides        <= 1'b0;
         cfg_ff.count_nonstandard     <= 1'b0;
         cfg_ff.peptide_length_limit  <= cct_pkg::PeptideLimitReset;
         cfg_ff.unknown_percent_limit <= cct_pkg::UnknownPctLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_name_ff    <= req_residue_name;
         s1_unknown_ff <= req_unknown_residue;
         s1_last_ff    <= req_last_residue;
      end
   end

   // class and count update
   cct_step #(
      .CountWidth (CountWidth)
   ) u_step (
      .state_cur       (state_ff),
      .residue_cur     (residue_cnt_ff),
      .unknown_cur     (unknown_cnt_ff),
      .residue_name    (s1_name_ff),
      .unknown_residue (s1_unknown_ff),
      .last_residue    (s1_last_ff),
      .cfg             (cfg_ff),
      .state_next      (state_in),
      .residue_next    (residue_cnt_in),
      .unknown_next    (unknown_cnt_in),
      .result_class    (step_class),
      .result_total    (step_total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.running_class <= cct_pkg::CLASS_UNDEF;
         state_ff.seen_uracil   <= 1'b0;
         residue_cnt_ff         <= '0;
         unknown_cnt_ff         <= '0;
      end else if (s1_adv) begin
         state_ff       <= state_in;
         residue_cnt_ff <= residue_cnt_in;
         unknown_cnt_ff <= unknown_cnt_in;
      end
   end

   // result register
   always_comb begin
      if (s1_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_emit) begin
         rsp_class_ff <= step_class;
         rsp_total_ff <= step_total;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chain_class   = rsp_class_ff;
   assign rsp_residue_total = rsp_total_ff;

   // checks
   `CCT_ASSERT_NEXT(a_emit_loads_rsp, clock, reset, s1_emit, rsp_valid_ff,
      "last residue did not produce a result")
   `CCT_ASSERT_NEXT(a_chain_cleared, clock, reset, s1_emit,
      residue_cnt_ff == '0 && unknown_cnt_ff == '0 &&
      state_ff.running_class == cct_pkg::CLASS_UNDEF && !state_ff.seen_uracil,
      "chain state not cleared after last residue")
   `CCT_ASSERT_NOW(a_unknown_le_total, clock, reset, 1'b1,
      unknown_cnt_ff <= residue_cnt_ff, "unknown count exceeds residue count")
   `CCT_ASSERT_NOW(a_total_nonzero, clock, reset, rsp_valid_ff,
      rsp_total_ff != '0, "result with zero residue total")

endmodule
